[rtl/rgp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rgp_pkg;
    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int DIM_W = 13;
    localparam int COORD_W = 12;
    localparam int GRAY_W = 8;
    localparam int QUOT_W = 33;
    localparam int RAD_W = 34;
    localparam int ROOT_W = 17;
    localparam int SREM_W = 20;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] KIND_CALC = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
    } ctl_t;
endpackage
`default_nettype wire

[rtl/rgp_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgp_div_cell #(
    parameter int MW = 25,
    parameter bit FIRST = 1'b0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire rgp_pkg::ctl_t               ctl_in,
    input  wire logic [MW-1:0]               m2_in,
    input  wire logic [MW-1:0]               rem_in,
    input  wire logic [rgp_pkg::QUOT_W-1:0]  q_in,
    output rgp_pkg::ctl_t                    ctl_reg,
    output logic [MW-1:0]                    m2_reg,
    output logic [MW-1:0]                    rem_reg,
    output logic [rgp_pkg::QUOT_W-1:0]       q_reg
);
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        take;

    always_comb
    begin
        trial = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
        take  = trial >= {1'b0, m2_in};
        diff  = trial - {1'b0, m2_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg  <= m2_in;
            rem_reg <= take ? diff[MW-1:0] : trial[MW-1:0];
            q_reg   <= {q_in[rgp_pkg::QUOT_W-2:0], take};
        end
    end
endmodule
`default_nettype wire

[rtl/rgp_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgp_sqrt_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire rgp_pkg::ctl_t               ctl_in,
    input  wire logic [rgp_pkg::RAD_W-1:0]   rad_in,
    input  wire logic [rgp_pkg::SREM_W-1:0]  rem_in,
    input  wire logic [rgp_pkg::ROOT_W-1:0]  root_in,
    output rgp_pkg::ctl_t                    ctl_reg,
    output logic [rgp_pkg::RAD_W-1:0]        rad_reg,
    output logic [rgp_pkg::SREM_W-1:0]       rem_reg,
    output logic [rgp_pkg::ROOT_W-1:0]       root_reg
);
    localparam int CW = rgp_pkg::SREM_W + 2;
    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          take;

    always_comb
    begin
        cur   = {rem_in, rad_in[rgp_pkg::RAD_W-1 -: 2]};
        trial = CW'({root_in, 2'b01});
        take  = cur >= trial;
        diff  = cur - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // remainder stays below 2*root + 1, so the top bits drop safely
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[rgp_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= take ? diff[rgp_pkg::SREM_W-1:0] : cur[rgp_pkg::SREM_W-1:0];
            root_reg <= {root_in[rgp_pkg::ROOT_W-2:0], take};
        end
    end
endmodule
`default_nettype wire

[rtl/radial_gradient_pattern.sv]
`timescale 1ns / 1ps
`default_nettype none
// Radial gradient test pattern. Each (pixel_x, pixel_y) transfer yields one gray level,
// 255 at the image centre falling linearly to 0 at the corners, 0 outside the image.
// Fully pipelined: one pixel per clock (3 front stages, 33 divider cells,
// 17 square-root cells, 1 output stage); the divider and square-root chains
// each retire one result bit per cell. The whole pipe stalls while the output
// transfer is held off. Width and height must be written on the config port only
// while the pipe is empty; the block itself does not enforce this.
module radial_gradient_pattern #(
    parameter int MAX_DIM = rgp_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [rgp_pkg::DIM_W-1:0]   cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,  // pixel_x[11:0], pixel_y[23:12]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata   // gray_level[7:0]
);
    localparam int DW = $clog2(MAX_DIM);
    localparam int MW = 2 * DW + 1;
    localparam int NDIV = rgp_pkg::QUOT_W;
    localparam int NSQ = rgp_pkg::ROOT_W;

    logic [rgp_pkg::DIM_W-1:0] width_reg, height_reg;
    logic en;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgp_pkg::WIDTH_RESET;
            height_reg <= rgp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rgp_pkg::REG_WIDTH)
                width_reg <= cfg_wdata;
            else
                height_reg <= cfg_wdata;
        end
    end

    // front end: clamp dimensions, doubled offsets
    logic [31:0] wc, hc, px, py, tx, ty, dxf, dyf;
    logic        outside;
    always_comb
    begin
        wc = 32'(width_reg);
        hc = 32'(height_reg);
        if (wc == 32'd0) wc = 32'd1;
        else if (wc > 32'(MAX_DIM)) wc = 32'(MAX_DIM);
        if (hc == 32'd0) hc = 32'd1;
        else if (hc > 32'(MAX_DIM)) hc = 32'(MAX_DIM);
        px = 32'(s_tdata[11:0]);
        py = 32'(s_tdata[23:12]);
        outside = (px >= wc) || (py >= hc);
        tx = px << 1;
        ty = py << 1;
        dxf = (tx >= wc - 32'd1) ? tx - (wc - 32'd1) : (wc - 32'd1) - tx;
        dyf = (ty >= hc - 32'd1) ? ty - (hc - 32'd1) : (hc - 32'd1) - ty;
    end

    rgp_pkg::ctl_t     ctl0_reg, ctl1_reg, ctl2_reg;
    logic [DW-1:0]     dx_reg, dy_reg, wm_reg, hm_reg;
    logic [2*DW-1:0]   dx2_reg, dy2_reg, wm2_reg, hm2_reg;
    logic [MW-1:0]     d2_reg, m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg.valid <= s_tvalid;
            ctl0_reg.kind  <= outside ? rgp_pkg::KIND_ZERO : rgp_pkg::KIND_CALC;
            ctl1_reg <= ctl0_reg;
            ctl2_reg.valid <= ctl1_reg.valid;
            if (ctl1_reg.kind == rgp_pkg::KIND_CALC && wm2_reg == '0 && hm2_reg == '0)
                ctl2_reg.kind <= rgp_pkg::KIND_FULL;
            else
                ctl2_reg.kind <= ctl1_reg.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dxf[DW-1:0];
            dy_reg  <= dyf[DW-1:0];
            wm_reg  <= DW'(wc - 32'd1);
            hm_reg  <= DW'(hc - 32'd1);
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
            wm2_reg <= wm_reg * wm_reg;
            hm2_reg <= hm_reg * hm_reg;
            d2_reg  <= MW'(dx2_reg) + MW'(dy2_reg);
            m2_reg  <= MW'(wm2_reg) + MW'(hm2_reg);
        end
    end

    // divider chain: q = floor(d2 * 2^32 / m2), d2 <= m2
    rgp_pkg::ctl_t               dctl [0:NDIV];
    logic [MW-1:0]               dm2  [0:NDIV];
    logic [MW-1:0]               drem [0:NDIV];
    logic [rgp_pkg::QUOT_W-1:0]  dq   [0:NDIV];

    assign dctl[0] = ctl2_reg;
    assign dm2[0]  = m2_reg;
    assign drem[0] = d2_reg;
    assign dq[0]   = '0;

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        rgp_div_cell #(.MW(MW), .FIRST(i == 0)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(dctl[i]), .m2_in(dm2[i]), .rem_in(drem[i]), .q_in(dq[i]),
            .ctl_reg(dctl[i+1]), .m2_reg(dm2[i+1]), .rem_reg(drem[i+1]), .q_reg(dq[i+1])
        );
    end

    // square-root chain, two radicand bits per cell
    rgp_pkg::ctl_t               sctl  [0:NSQ];
    logic [rgp_pkg::RAD_W-1:0]   srad  [0:NSQ];
    logic [rgp_pkg::SREM_W-1:0]  srem  [0:NSQ];
    logic [rgp_pkg::ROOT_W-1:0]  sroot [0:NSQ];

    assign sctl[0]  = dctl[NDIV];
    assign srad[0]  = rgp_pkg::RAD_W'(dq[NDIV]);
    assign srem[0]  = '0;
    assign sroot[0] = '0;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        rgp_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(sctl[k]), .rad_in(srad[k]), .rem_in(srem[k]), .root_in(sroot[k]),
            .ctl_reg(sctl[k+1]), .rad_reg(srad[k+1]), .rem_reg(srem[k+1]),
            .root_reg(sroot[k+1])
        );
    end

    // gray = (255 * (65536 - t) + 32768) >> 16
    logic [16:0] inv;
    logic [25:0] prod;
    logic [7:0]  gray;
    rgp_pkg::ctl_t fctl;
    always_comb
    begin
        fctl = sctl[NSQ];
        inv  = 17'h10000 - sroot[NSQ];
        prod = (26'({inv, 8'h00}) - 26'(inv)) + 26'h8000;
        unique case (fctl.kind)
            rgp_pkg::KIND_ZERO: gray = 8'd0;
            rgp_pkg::KIND_FULL: gray = 8'd255;
            default:            gray = prod[23:16];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= fctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= gray;
        end
    end
endmodule
`default_nettype wire

[rtl/rgp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    // a stalled output transfer holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // a stalled output stalls the whole pipe
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    // input is held off only by a pending output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without output stall");
endmodule

bind radial_gradient_pattern rgp_checker u_rgp_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
